/* rtl/fpma_pkg.sv */
`default_nettype none
package fpma_pkg;

    localparam int PAGES = 4096;
    localparam int PW    = $clog2(PAGES);
    localparam int NW    = PW + 1;
    localparam int CW    = 13;
    localparam int LW    = CW + 1;
    localparam int MW    = PW + 1;
    localparam int OW    = PW + CW;
    localparam int SW    = 2;

    localparam logic [NW-1:0] PAGES_N = NW'(PAGES);

    localparam logic CFG_BLOCK_COUNT     = 1'b0;
    localparam logic CFG_PAGES_PER_BLOCK = 1'b1;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DENIED  = 2'd1;
    localparam logic [1:0] STATUS_NO_FREE = 2'd2;

    localparam logic [SW-1:0] ST_FREE     = 2'd0;
    localparam logic [SW-1:0] ST_VALID    = 2'd1;
    localparam logic [SW-1:0] ST_INVALID  = 2'd2;
    localparam logic [SW-1:0] ST_UNMAPPED = 2'd3;

    typedef enum logic [2:0] {
        CMD_MAP_RANGE   = 3'd0,
        CMD_MAP_AVOID   = 3'd1,
        CMD_LOOKUP      = 3'd2,
        CMD_INVALIDATE  = 3'd3,
        CMD_SET_STATE   = 3'd4,
        CMD_GET_STATE   = 3'd5,
        CMD_SEEK_FREE   = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [NW-1:0] usable;
        logic [CW-1:0] ppb;
    } geom_t;

    typedef struct packed {
        logic          we;
        logic [PW-1:0] addr;
        logic [MW-1:0] wdata;
    } map_req_t;

    typedef struct packed {
        logic          we;
        logic [PW-1:0] addr;
        logic [SW-1:0] wdata;
    } st_req_t;

    typedef struct packed {
        logic [1:0]    status;
        logic [PW-1:0] phys;
        logic [SW-1:0] pst;
        logic          ro;
        logic [31:0]   wcnt;
    } result_t;

endpackage
`default_nettype wire

/* rtl/flash_page_map_allocator.sv */
`default_nettype none
// Page-mapped flash translation engine. After reset the block clears all PAGES entries of
// both page tables (4096 at the default size) before it takes its first command beat;
// configuration writes are taken throughout. One command is worked at a time, and each
// table access goes through a synchronous memory read: set state and bad commands
// finish without a table read, get state reads the state table, lookup reads the map
// and then the state table, invalidate reads both for each page, and every allocation
// or seek walks the page-state memory one probed page at a time. A finished result
// waits in the output register while the next command beat is accepted.
module flash_page_map_allocator
    import fpma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // logical_page, page_count, page_number, block_number, state_value
    input  wire logic [55:0] s_axis_tdata,
    // command
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // physical_page, page_state, locked, written_count
    output logic [47:0]      m_axis_tdata,
    // status
    output logic [1:0]       m_axis_tuser
);

    logic [CW-1:0]   bc_reg;
    logic [CW-1:0]   ppb_reg;
    logic [NW-1:0]   usable;
    logic [2*CW-1:0] prod;
    geom_t           geom;
    result_t         res;
    map_req_t        map_req;
    st_req_t         st_req;
    logic [MW-1:0]   map_rdata;
    logic [SW-1:0]   st_rdata;

    assign prod   = (2 * CW)'(bc_reg) * (2 * CW)'(ppb_reg);
    assign usable = (prod > (2 * CW)'(PAGES)) ? PAGES_N : prod[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg  <= CW'(16);
            ppb_reg <= CW'(64);
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_BLOCK_COUNT)
            begin
                bc_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_PAGES_PER_BLOCK)
            begin
                ppb_reg <= cfg_data;
            end
        end
    end

    assign geom.usable = usable;
    assign geom.ppb    = ppb_reg;

    fpma_ram #(.WIDTH(MW), .DEPTH(PAGES)) u_map_ram (
        .clk   (clk),
        .we    (map_req.we),
        .addr  (map_req.addr),
        .wdata (map_req.wdata),
        .rdata (map_rdata)
    );

    fpma_ram #(.WIDTH(SW), .DEPTH(PAGES)) u_state_ram (
        .clk   (clk),
        .we    (st_req.we),
        .addr  (st_req.addr),
        .wdata (st_req.wdata),
        .rdata (st_rdata)
    );

    fpma_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (s_axis_tuser),
        .in_lpage  (s_axis_tdata[11:0]),
        .in_count  (s_axis_tdata[24:12]),
        .in_ppage  (s_axis_tdata[36:25]),
        .in_blk    (s_axis_tdata[48:37]),
        .in_sval   (s_axis_tdata[50:49]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .map_req   (map_req),
        .map_rdata (map_rdata),
        .st_req    (st_req),
        .st_rdata  (st_rdata)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {1'b0, res.wcnt, res.ro, res.pst, res.phys};

endmodule
`default_nettype wire

/* rtl/fpma_ram.sv */
`default_nettype none
module fpma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* rtl/fpma_seq.sv */
`default_nettype none
module fpma_seq
    import fpma_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire geom_t         geom,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [2:0]    in_cmd,
    input  wire logic [PW-1:0] in_lpage,
    input  wire logic [CW-1:0] in_count,
    input  wire logic [PW-1:0] in_ppage,
    input  wire logic [PW-1:0] in_blk,
    input  wire logic [SW-1:0] in_sval,
    output logic               out_valid,
    input  wire logic          out_ready,
    output result_t            out_res,
    output map_req_t           map_req,
    input  wire logic [MW-1:0] map_rdata,
    output st_req_t            st_req,
    input  wire logic [SW-1:0] st_rdata
);

    typedef enum logic [14:0] {
        S_CLR      = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_CHK_RD   = 15'b000000000000100,
        S_CHK_CK   = 15'b000000000001000,
        S_ALLOC    = 15'b000000000010000,
        S_SCAN_RD  = 15'b000000000100000,
        S_SCAN_CK  = 15'b000000001000000,
        S_ALLOC_WR = 15'b000000010000000,
        S_LOOK_MAP = 15'b000000100000000,
        S_LOOK_ST  = 15'b000001000000000,
        S_INV_RD   = 15'b000010000000000,
        S_INV_MAP  = 15'b000100000000000,
        S_INV_ST   = 15'b001000000000000,
        S_GET      = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } fsm_t;

    typedef enum logic [1:0] {
        SC_ALLOC = 2'd0,
        SC_NEXT  = 2'd1,
        SC_SEEK  = 2'd2
    } scan_t;

    fsm_t          state_reg;
    scan_t         phase_reg;
    logic [PW-1:0] clr_reg;
    logic [PW-1:0] scan_p_reg;
    logic [NW-1:0] scan_i_reg;
    logic          avoid_reg;
    logic [PW-1:0] found_reg;
    logic [PW-1:0] inv_p_reg;
    logic [PW-1:0] fp_reg;
    logic          ro_reg;
    logic [31:0]   wcnt_reg;
    logic [LW-1:0] cur_lp_reg;
    logic [CW-1:0] left_reg;
    logic [PW-1:0] lpage_reg;
    logic [CW-1:0] count_reg;
    logic [OW-1:0] lo_reg;
    logic [1:0]    status_reg;
    logic [PW-1:0] phys_reg;
    logic [SW-1:0] pst_reg;
    logic          out_valid_reg;
    result_t       res_reg;
    logic          is_avoid_reg;

    logic          accept;
    logic          set_ok;
    logic [NW-1:0] n;
    logic [OW:0]   hi;
    logic          skip;
    logic [NW-1:0] p_inc;

    function automatic logic [PW-1:0] first_page(logic [NW-1:0] start, logic [NW-1:0] lim);
        first_page = (start < lim) ? start[PW-1:0] : '0;
    endfunction

    assign n        = geom.usable;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign set_ok   = ({1'b0, in_ppage} < n) && (in_sval != ST_UNMAPPED);
    assign hi       = {1'b0, lo_reg} + (OW + 1)'(geom.ppb);
    assign skip     = avoid_reg && ((OW + 1)'(scan_p_reg) >= {1'b0, lo_reg})
                      && ((OW + 1)'(scan_p_reg) < hi);
    assign p_inc    = {1'b0, scan_p_reg} + NW'(1);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        map_req = '0;
        st_req  = '0;
        case (state_reg)
            S_CLR:
            begin
                map_req.we   = 1'b1;
                map_req.addr = clr_reg;
                st_req.we    = 1'b1;
                st_req.addr  = clr_reg;
            end
            S_IDLE:
            begin
                map_req.addr = in_lpage;
                st_req.addr  = in_ppage;
                st_req.wdata = in_sval;
                st_req.we    = accept && (cmd_t'(in_cmd) == CMD_SET_STATE) && set_ok;
            end
            S_CHK_RD, S_INV_RD:
            begin
                map_req.addr = cur_lp_reg[PW-1:0];
            end
            S_SCAN_RD:
            begin
                st_req.addr = scan_p_reg;
            end
            S_ALLOC_WR:
            begin
                map_req.we    = 1'b1;
                map_req.addr  = cur_lp_reg[PW-1:0];
                map_req.wdata = {1'b1, found_reg};
                st_req.we     = 1'b1;
                st_req.addr   = found_reg;
                st_req.wdata  = ST_VALID;
            end
            S_LOOK_MAP, S_INV_MAP:
            begin
                st_req.addr = map_rdata[PW-1:0];
            end
            S_INV_ST:
            begin
                st_req.addr  = inv_p_reg;
                st_req.wdata = ST_INVALID;
                st_req.we    = (st_rdata == ST_VALID);
            end
            default:
            begin
                map_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            fp_reg        <= '0;
            ro_reg        <= 1'b0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= SC_ALLOC;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + PW'(1);
                    if (clr_reg == PW'(PAGES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= STATUS_OK;
                        phys_reg   <= '0;
                        pst_reg    <= ST_FREE;
                        lpage_reg  <= in_lpage;
                        count_reg  <= in_count;
                        cur_lp_reg <= LW'(in_lpage);
                        left_reg   <= in_count;
                        lo_reg     <= OW'(in_blk) * OW'(geom.ppb);
                        state_reg  <= S_DONE;
                        case (cmd_t'(in_cmd))
                            CMD_MAP_RANGE:
                            begin
                                state_reg <= S_CHK_RD;
                            end
                            CMD_MAP_AVOID:
                            begin
                                left_reg <= CW'(1);
                                if ({1'b0, in_lpage} >= n)
                                begin
                                    status_reg <= STATUS_DENIED;
                                end
                                else
                                begin
                                    state_reg <= S_ALLOC;
                                end
                            end
                            CMD_LOOKUP:
                            begin
                                if ({1'b0, in_lpage} < n)
                                begin
                                    state_reg <= S_LOOK_MAP;
                                end
                                else
                                begin
                                    pst_reg <= ST_UNMAPPED;
                                end
                            end
                            CMD_INVALIDATE:
                            begin
                                state_reg <= S_INV_RD;
                            end
                            CMD_SET_STATE:
                            begin
                                if (set_ok)
                                begin
                                    pst_reg <= in_sval;
                                end
                                else
                                begin
                                    status_reg <= STATUS_DENIED;
                                end
                            end
                            CMD_GET_STATE:
                            begin
                                if ({1'b0, in_ppage} < n)
                                begin
                                    state_reg <= S_GET;
                                end
                                else
                                begin
                                    status_reg <= STATUS_DENIED;
                                end
                            end
                            CMD_SEEK_FREE:
                            begin
                                scan_p_reg <= first_page({1'b0, in_ppage}, n);
                                scan_i_reg <= '0;
                                avoid_reg  <= 1'b0;
                                phase_reg  <= SC_SEEK;
                                state_reg  <= S_SCAN_RD;
                            end
                            default:
                            begin
                                status_reg <= STATUS_DENIED;
                            end
                        endcase
                    end
                end
                S_CHK_RD:
                begin
                    if (left_reg == '0)
                    begin
                        cur_lp_reg <= LW'(lpage_reg);
                        left_reg   <= count_reg;
                        state_reg  <= S_ALLOC;
                    end
                    else if (cur_lp_reg >= LW'(n))
                    begin
                        status_reg <= STATUS_DENIED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CHK_CK;
                    end
                end
                S_CHK_CK:
                begin
                    if (map_rdata[PW])
                    begin
                        status_reg <= STATUS_DENIED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        cur_lp_reg <= cur_lp_reg + LW'(1);
                        left_reg   <= left_reg - CW'(1);
                        state_reg  <= S_CHK_RD;
                    end
                end
                S_ALLOC:
                begin
                    if (left_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (ro_reg)
                    begin
                        status_reg <= STATUS_NO_FREE;
                        phys_reg   <= '0;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        scan_p_reg <= first_page({1'b0, fp_reg}, n);
                        scan_i_reg <= '0;
                        avoid_reg  <= is_avoid_reg;
                        phase_reg  <= SC_ALLOC;
                        state_reg  <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    if (scan_i_reg >= n)
                    begin
                        ro_reg <= 1'b1;
                        case (phase_reg)
                            SC_NEXT:
                            begin
                                phys_reg   <= found_reg;
                                left_reg   <= left_reg - CW'(1);
                                cur_lp_reg <= cur_lp_reg + LW'(1);
                                state_reg  <= S_ALLOC;
                            end
                            default:
                            begin
                                status_reg <= STATUS_NO_FREE;
                                phys_reg   <= '0;
                                state_reg  <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK:
                begin
                    if (!skip && (st_rdata == ST_FREE))
                    begin
                        case (phase_reg)
                            SC_ALLOC:
                            begin
                                found_reg <= scan_p_reg;
                                state_reg <= S_ALLOC_WR;
                            end
                            SC_NEXT:
                            begin
                                fp_reg     <= scan_p_reg;
                                phys_reg   <= found_reg;
                                left_reg   <= left_reg - CW'(1);
                                cur_lp_reg <= cur_lp_reg + LW'(1);
                                state_reg  <= S_ALLOC;
                            end
                            default:
                            begin
                                fp_reg    <= scan_p_reg;
                                phys_reg  <= scan_p_reg;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        scan_p_reg <= (p_inc >= n) ? '0 : p_inc[PW-1:0];
                        scan_i_reg <= scan_i_reg + NW'(1);
                        state_reg  <= S_SCAN_RD;
                    end
                end
                S_ALLOC_WR:
                begin
                    if (wcnt_reg != 32'hFFFF_FFFF)
                    begin
                        wcnt_reg <= wcnt_reg + 32'd1;
                    end
                    scan_p_reg <= first_page({1'b0, found_reg} + NW'(1), n);
                    scan_i_reg <= '0;
                    avoid_reg  <= 1'b0;
                    phase_reg  <= SC_NEXT;
                    state_reg  <= S_SCAN_RD;
                end
                S_LOOK_MAP:
                begin
                    if (map_rdata[PW])
                    begin
                        phys_reg  <= map_rdata[PW-1:0];
                        state_reg <= S_LOOK_ST;
                    end
                    else
                    begin
                        pst_reg   <= ST_UNMAPPED;
                        state_reg <= S_DONE;
                    end
                end
                S_LOOK_ST, S_GET:
                begin
                    pst_reg   <= st_rdata;
                    state_reg <= S_DONE;
                end
                S_INV_RD:
                begin
                    if (left_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (cur_lp_reg >= LW'(n))
                    begin
                        status_reg <= STATUS_DENIED;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_INV_MAP;
                    end
                end
                S_INV_MAP:
                begin
                    inv_p_reg <= map_rdata[PW-1:0];
                    if (map_rdata[PW])
                    begin
                        state_reg <= S_INV_ST;
                    end
                    else
                    begin
                        status_reg <= STATUS_DENIED;
                        state_reg  <= S_DONE;
                    end
                end
                S_INV_ST:
                begin
                    if (st_rdata == ST_VALID)
                    begin
                        cur_lp_reg <= cur_lp_reg + LW'(1);
                        left_reg   <= left_reg - CW'(1);
                        state_reg  <= S_INV_RD;
                    end
                    else
                    begin
                        status_reg <= STATUS_DENIED;
                        state_reg  <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        res_reg.status <= status_reg;
                        res_reg.phys   <= phys_reg;
                        res_reg.pst    <= pst_reg;
                        res_reg.ro     <= ro_reg;
                        res_reg.wcnt   <= wcnt_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // avoid only for the single-page map command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_avoid_reg <= 1'b0;
        end
        else if (accept)
        begin
            is_avoid_reg <= (cmd_t'(in_cmd) == CMD_MAP_AVOID);
        end
    end

    a_ro_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ro_reg |=> ro_reg)
        else $error("read-only flag cleared");

    a_wcnt_only_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_ALLOC_WR) |=> $stable(wcnt_reg))
        else $error("write count moved outside an allocation");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !in_ready)
        else $error("input taken during table clear");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result dropped while output stalled");

endmodule
`default_nettype wire

/* tb/fpma_checker.sv */
module fpma_checker
    import fpma_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    output int               mismatches,
    output int               outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] phys;
        logic [1:0]  pst;
        logic        ro;
        logic [31:0] wcnt;
    } answer_t;

    logic [12:0] blocks;
    logic [12:0] ppb;
    logic [11:0] l2p [PAGES];
    bit          l2p_ok [PAGES];
    logic [1:0]  pstate [PAGES];
    int          free_ptr;
    bit          ro_flag;
    logic [31:0] wcount;
    answer_t     answers_due [$];

    function automatic int usable_pages();
        longint n;
        n = longint'(blocks) * longint'(ppb);
        return (n > PAGES) ? PAGES : int'(n);
    endfunction

    function automatic bit find_free(int start, int n, bit avoid, longint lo, longint hi,
                                     output int found);
        int p;
        bit skip;
        p = (start < n) ? start : 0;
        found = 0;
        for (int i = 0; i < n; i++)
        begin
            skip = avoid && p >= lo && p < hi;
            if (!skip && pstate[p] == ST_FREE)
            begin
                found = p;
                return 1'b1;
            end
            p = (p + 1 >= n) ? 0 : p + 1;
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] grab_page(int lp, bit avoid, longint lo, longint hi,
                                             output int pp);
        int n;
        int p;
        int nx;
        n = usable_pages();
        pp = 0;
        if (ro_flag)
            return STATUS_NO_FREE;
        if (!find_free(free_ptr, n, avoid, lo, hi, p))
        begin
            ro_flag = 1'b1;
            return STATUS_NO_FREE;
        end
        l2p[lp] = p[11:0];
        l2p_ok[lp] = 1'b1;
        pstate[p] = ST_VALID;
        if (wcount != 32'hFFFF_FFFF)
            wcount = wcount + 1;
        if (find_free(p + 1, n, 1'b0, 0, 0, nx))
            free_ptr = nx;
        else
            ro_flag = 1'b1;
        pp = p;
        return STATUS_OK;
    endfunction

    function automatic answer_t translate(logic [2:0] cmd, logic [55:0] d);
        answer_t a;
        int lpage, count, ppage, lp, p, n, phys;
        longint lo;
        logic [1:0] sval;
        logic [1:0] st;
        lpage = d[11:0];
        count = d[24:12];
        ppage = d[36:25];
        lo    = longint'(d[48:37]) * longint'(ppb);
        sval  = d[50:49];
        n = usable_pages();
        st = STATUS_OK;
        phys = 0;
        a.pst = ST_FREE;
        case (cmd)
            CMD_MAP_RANGE:
            begin
                for (int i = 0; i < count; i++)
                begin
                    lp = lpage + i;
                    if (lp >= n || l2p_ok[lp])
                    begin
                        st = STATUS_DENIED;
                        break;
                    end
                end
                if (st == STATUS_OK)
                    for (int i = 0; i < count; i++)
                    begin
                        st = grab_page(lpage + i, 1'b0, 0, 0, p);
                        if (st != STATUS_OK)
                        begin
                            phys = 0;
                            break;
                        end
                        phys = p;
                    end
            end
            CMD_MAP_AVOID:
            begin
                if (lpage >= n)
                    st = STATUS_DENIED;
                else
                begin
                    st = grab_page(lpage, 1'b1, lo, lo + ppb, p);
                    if (st == STATUS_OK)
                        phys = p;
                end
            end
            CMD_LOOKUP:
            begin
                if (lpage < n && l2p_ok[lpage])
                begin
                    phys = l2p[lpage];
                    a.pst = pstate[phys];
                end
                else
                    a.pst = ST_UNMAPPED;
            end
            CMD_INVALIDATE:
            begin
                for (int i = 0; i < count; i++)
                begin
                    lp = lpage + i;
                    if (lp >= n || !l2p_ok[lp] || pstate[l2p[lp]] != ST_VALID)
                    begin
                        st = STATUS_DENIED;
                        break;
                    end
                    pstate[l2p[lp]] = ST_INVALID;
                end
            end
            CMD_SET_STATE:
            begin
                if (ppage >= n || sval == ST_UNMAPPED)
                    st = STATUS_DENIED;
                else
                begin
                    pstate[ppage] = sval;
                    a.pst = sval;
                end
            end
            CMD_GET_STATE:
            begin
                if (ppage >= n)
                    st = STATUS_DENIED;
                else
                    a.pst = pstate[ppage];
            end
            CMD_SEEK_FREE:
            begin
                if (find_free(ppage, n, 1'b0, 0, 0, p))
                begin
                    free_ptr = p;
                    phys = p;
                end
                else
                begin
                    ro_flag = 1'b1;
                    st = STATUS_NO_FREE;
                end
            end
            default:
                st = STATUS_DENIED;
        endcase
        a.status = st;
        a.phys = phys[11:0];
        a.ro = ro_flag;
        a.wcnt = wcount;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        answer_t got;
        if (!rst_n)
        begin
            blocks = 13'd16;
            ppb = 13'd64;
            for (int i = 0; i < PAGES; i++)
            begin
                l2p[i] = '0;
                l2p_ok[i] = 1'b0;
                pstate[i] = ST_FREE;
            end
            free_ptr = 0;
            ro_flag = 1'b0;
            wcount = '0;
            answers_due.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BLOCK_COUNT)
                    blocks = cfg_data;
                else
                    ppb = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[13:12],
                       m_axis_tdata[14], m_axis_tdata[46:15]};
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %h", got);
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: status %0d/%0d phys %0d/%0d pst %0d/%0d ro %0d/%0d cnt %0d/%0d (exp/got)",
                                     want.status, got.status, want.phys, got.phys,
                                     want.pst, got.pst, want.ro, got.ro,
                                     want.wcnt, got.wcnt);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                answers_due.push_back(translate(s_axis_tuser, s_axis_tdata));
            outstanding = answers_due.size();
        end
    end

endmodule

/* tb/tb_top.sv */
module tb_top;
    import fpma_pkg::*;

    localparam logic [2:0] CMD_RESERVED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    int          mismatches;
    int          outstanding;
    int          burst_left;
    int          stall_mode;
    int          stall_left;
    int          n_now;

    flash_page_map_allocator u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    fpma_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern: always ready, random, or long stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_cmd(logic [2:0] cmd, logic [11:0] lpage, logic [12:0] count,
                            logic [11:0] ppage, logic [11:0] blk, logic [1:0] sval);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        s_axis_tuser = cmd;
        s_axis_tdata = {5'd0, sval, blk, ppage, count, lpage};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_geometry(logic [12:0] bc, logic [12:0] ppb);
        longint n;
        write_reg(CFG_BLOCK_COUNT, bc);
        write_reg(CFG_PAGES_PER_BLOCK, ppb);
        n = longint'(bc) * longint'(ppb);
        n_now = (n > PAGES) ? PAGES : int'(n);
    endtask

    function automatic logic [11:0] pick_page();
        if (n_now > 0 && $urandom_range(0, 9) != 0)
            return 12'($urandom_range(0, n_now - 1));
        return 12'($urandom);
    endfunction

    function automatic logic [12:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return 13'($urandom_range(0, 6));
        if (r < 97)
            return 13'($urandom_range(7, 64));
        return 13'($urandom);
    endfunction

    task automatic random_items(int total);
        logic [2:0] cmd;
        int r;
        for (int k = 0; k < total; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                cmd = CMD_MAP_RANGE;
            else if (r < 35)
                cmd = CMD_MAP_AVOID;
            else if (r < 55)
                cmd = CMD_LOOKUP;
            else if (r < 68)
                cmd = CMD_INVALIDATE;
            else if (r < 78)
                cmd = CMD_SET_STATE;
            else if (r < 88)
                cmd = CMD_GET_STATE;
            else if (r < 97)
                cmd = CMD_SEEK_FREE;
            else
                cmd = CMD_RESERVED;
            send_cmd(cmd, pick_page(), pick_count(), pick_page(), 12'($urandom),
                     2'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;
        n_now = 1024;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        set_geometry(13'd16, 13'd64);
        send_cmd(CMD_MAP_RANGE, 12'd0, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_MAP_RANGE, 12'd0, 13'd3, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_MAP_RANGE, 12'd0, 13'd1, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_MAP_RANGE, 12'd1020, 13'd8, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_LOOKUP, 12'd0, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_LOOKUP, 12'd4095, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_LOOKUP, 12'd5, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_MAP_AVOID, 12'd10, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_MAP_AVOID, 12'd2000, 13'd0, 12'd0, 12'd4095, 2'd0);
        send_cmd(CMD_INVALIDATE, 12'd0, 13'd2, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_INVALIDATE, 12'd0, 13'd3, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_INVALIDATE, 12'd0, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_SET_STATE, 12'd0, 13'd0, 12'd4095, 12'd0, ST_VALID);
        send_cmd(CMD_SET_STATE, 12'd0, 13'd0, 12'd7, 12'd0, ST_UNMAPPED);
        send_cmd(CMD_SET_STATE, 12'd0, 13'd0, 12'd7, 12'd0, ST_INVALID);
        send_cmd(CMD_GET_STATE, 12'd0, 13'd0, 12'd7, 12'd0, 2'd0);
        send_cmd(CMD_GET_STATE, 12'd0, 13'd0, 12'd4095, 12'd0, 2'd0);
        send_cmd(CMD_SEEK_FREE, 12'd0, 13'd0, 12'd4095, 12'd0, 2'd0);
        send_cmd(CMD_SEEK_FREE, 12'd0, 13'd0, 12'd0, 12'd0, 2'd0);
        send_cmd(CMD_RESERVED, 12'hFFF, 13'h1FFF, 12'hFFF, 12'hFFF, 2'd3);
        send_cmd(CMD_LOOKUP, 12'd10, 13'd0, 12'd0, 12'd0, 2'd0);
        random_items(200);
        drain();

        set_geometry(13'd4096, 13'd4096);
        random_items(200);
        drain();
        set_geometry(13'd1, 13'd4096);
        random_items(150);
        drain();
        set_geometry(13'd8191, 13'd8191);
        random_items(150);
        drain();
        set_geometry(13'd3, 13'd5);
        random_items(150);
        drain();
        set_geometry(13'd1, 13'd1);
        random_items(100);
        drain();
        set_geometry(13'd0, 13'd7);
        random_items(100);
        drain();
        set_geometry(13'd16, 13'd64);
        random_items(100);
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fpma_pkg.sv
rtl/fpma_ram.sv
rtl/fpma_seq.sv
rtl/flash_page_map_allocator.sv
tb/fpma_checker.sv
tb/tb_top.sv
